### rtl/qvt_pkg.sv
// Package for the quorum vote tally: field widths, command, status and
// register codes, reset values and default sizes. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package qvt_pkg;

   // default sizes for the top-level parameters
   localparam int SLOTS_DEF       = 4;
   localparam int NODES_DEF       = 16;
   localparam int DIGEST_BITS_DEF = 64;

   // fixed field widths
   localparam int CMD_W      = 2;
   localparam int SENDER_W   = 4;
   localparam int LEN_W      = 12;
   localparam int TAG_W      = 8;
   localparam int DIGEST_W   = 64;
   localparam int STATUS_W   = 3;
   localparam int THR_W      = 5;
   localparam int SLOT_OUT_W = 2;
   localparam int USED_OUT_W = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // commands; any code at or above CMD_CLEAR clears the table
   localparam logic [CMD_W-1:0] CMD_PEER  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_OWN   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

   typedef enum logic [STATUS_W-1:0] {
      ST_MATCHED    = 3'd0,
      ST_STORED     = 3'd1,
      ST_BAD_LEN    = 3'd2,
      ST_DUP_SENDER = 3'd3,
      ST_SHORT_TAG  = 3'd4,
      ST_FULL       = 3'd5,
      ST_CLEARED    = 3'd6
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_THRESHOLD    = 2'd0,
      CSR_EXPECTED_TAG = 2'd1,
      CSR_MAX_MSG_LEN  = 2'd2,
      CSR_MIN_MSG_LEN  = 2'd3
   } csr_idx_type;

   localparam logic [THR_W-1:0] THRESHOLD_RST   = 5'd1;
   localparam logic [TAG_W-1:0] EXP_TAG_RST     = 8'd0;
   localparam logic [LEN_W-1:0] MAX_MSG_LEN_RST = 12'd4095;
   localparam logic [LEN_W-1:0] MIN_MSG_LEN_RST = 12'd48;

endpackage
`default_nettype wire

### rtl/qvt_req_if.sv
// Vote request channel: valid/ready plus one vote or clear command.
// Depends on qvt_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none
interface qvt_req_if;
   import qvt_pkg::*;

   logic                valid;
   logic                ready;
   logic [CMD_W-1:0]    cmd;
   logic [SENDER_W-1:0] sender;
   logic [LEN_W-1:0]    msg_len;
   logic [TAG_W-1:0]    msg_tag;
   logic [DIGEST_W-1:0] digest;

   modport source (output valid, cmd, sender, msg_len, msg_tag, digest, input ready);
   modport sink   (input valid, cmd, sender, msg_len, msg_tag, digest, output ready);
endinterface
`default_nettype wire

### rtl/qvt_rsp_if.sv
// Tally response channel: valid/ready plus status and certificate state.
// Depends on qvt_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none
interface qvt_rsp_if;
   import qvt_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [STATUS_W-1:0]   status;
   logic                  complete;
   logic [SLOT_OUT_W-1:0] complete_slot;
   logic [DIGEST_W-1:0]   complete_digest;
   logic                  own_valid;
   logic [SLOT_OUT_W-1:0] own_slot;
   logic [USED_OUT_W-1:0] used_slots;

   modport source (output valid, status, complete, complete_slot, complete_digest,
                   own_valid, own_slot, used_slots, input ready);
   modport sink   (input valid, status, complete, complete_slot, complete_digest,
                   own_valid, own_slot, used_slots, output ready);
endinterface
`default_nettype wire

### rtl/qvt_csr_if.sv
// Register write channel: valid/ready, register index and write data.
// Depends on qvt_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none
interface qvt_csr_if;
   import qvt_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

### rtl/qvt_ram.sv
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No package dependencies.
`timescale 1ns / 1ps
`default_nettype none
module qvt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              we,
   input  wire logic [ADDR_W-1:0] waddr,
   input  wire logic [WIDTH-1:0]  wdata,
   input  wire logic [ADDR_W-1:0] raddr,
   output      logic [WIDTH-1:0]  rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule
`default_nettype wire

### rtl/quorum_vote_tally_core.sv
// Quorum vote tally top level. Uses qvt_pkg, the qvt_req_if, qvt_rsp_if and
// qvt_csr_if channels and one qvt_ram instance for the slot table.
//
// Usage:
//   req_ch carries one transaction per vote (peer or own) or clear command.
//   rsp_ch returns exactly one transaction per request: status, the first
//   slot whose count reaches the threshold, own slot and used slot count,
//   all as they stand after the request is applied.
//   csr_ch writes threshold, expected tag and the length limits; it is
//   always ready and should only be used while no request is in flight.
// Sequencing:
//   One request at a time. A vote walks over the used table entries, one read
//   of the slot RAM per cycle, before its response; a clear, or a vote on an
//   empty table, skips the walk and goes straight to the response.
// Reset:
//   Synchronous, active high. Registers return to their defaults, the used
//   count, voter mask and own slot are cleared. RAM entries at or beyond the
//   used count are never read, so the RAM needs no clearing pass.
// Stall:
//   The response sits in an output register; a new request is accepted while
//   it waits. The next response holds in the final state until rsp_ch drains.
`timescale 1ns / 1ps
`default_nettype none
module quorum_vote_tally_core #(
   parameter int SLOTS       = qvt_pkg::SLOTS_DEF,
   parameter int NODES       = qvt_pkg::NODES_DEF,
   parameter int DIGEST_BITS = qvt_pkg::DIGEST_BITS_DEF
) (
   input wire logic  clock,
   input wire logic  reset,
   qvt_req_if.sink   req_ch,
   qvt_rsp_if.source rsp_ch,
   qvt_csr_if.sink   csr_ch
);
   import qvt_pkg::*;

   localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int USED_W  = $clog2(SLOTS + 1);
   localparam int ID_W    = $clog2(NODES);
   localparam int CNT_W   = $clog2(NODES + 1);
   localparam int ENTRY_W = CNT_W + DIGEST_BITS;

   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_WALK   = 3'b010,
      S_FINISH = 3'b100
   } state_type;

   state_type state_ff, state_in;

   // configuration registers
   logic [THR_W-1:0] thr_ff, thr_in;
   logic [TAG_W-1:0] tag_ff, tag_in;
   logic [LEN_W-1:0] max_len_ff, max_len_in;
   logic [LEN_W-1:0] min_len_ff, min_len_in;

   // table control state
   logic [NODES-1:0]  mask_ff, mask_in;
   logic [USED_W-1:0] used_ff, used_in;
   logic              own_valid_ff, own_valid_in;
   logic [SLOT_W-1:0] own_slot_ff, own_slot_in;

   // current request
   logic                   clear_ff, clear_in;
   logic                   own_ff, own_in;
   logic                   vote_ok_ff, vote_ok_in;
   status_type             status_ff, status_in;
   logic [DIGEST_BITS-1:0] dig_ff, dig_in;
   logic [ID_W-1:0]        who_ff, who_in;

   // walk over the table
   logic [USED_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic                   rvalid_ff, rvalid_in;
   logic [SLOT_W-1:0]      proc_idx_ff, proc_idx_in;
   logic                   matched_ff, matched_in;
   logic                   done_ff, done_in;
   logic [SLOT_W-1:0]      cslot_ff, cslot_in;
   logic [DIGEST_BITS-1:0] cdig_ff, cdig_in;

   // response register
   logic                   rsp_valid_ff, rsp_valid_in;
   status_type             rsp_status_ff, rsp_status_in;
   logic                   rsp_done_ff, rsp_done_in;
   logic [SLOT_W-1:0]      rsp_cslot_ff, rsp_cslot_in;
   logic [DIGEST_BITS-1:0] rsp_cdig_ff, rsp_cdig_in;
   logic                   rsp_own_valid_ff, rsp_own_valid_in;
   logic [SLOT_W-1:0]      rsp_own_slot_ff, rsp_own_slot_in;
   logic [USED_W-1:0]      rsp_used_ff, rsp_used_in;

   // RAM ports
   logic                   ram_we;
   logic [SLOT_W-1:0]      ram_waddr;
   logic [ENTRY_W-1:0]     ram_wdata;
   logic [SLOT_W-1:0]      ram_raddr;
   logic [ENTRY_W-1:0]     ram_rdata;

   // combinational helpers
   logic                   accept;
   logic                   is_clear;
   logic                   len_bad;
   logic                   dup;
   logic                   short_tag;
   logic [ID_W-1:0]        who_idx;
   logic                   issue;
   logic [CNT_W-1:0]       rd_cnt;
   logic [DIGEST_BITS-1:0] rd_dig;
   logic                   hit;
   logic [CNT_W-1:0]       new_cnt;
   logic                   last;
   logic                   rsp_free;
   logic                   store_new;

   // slot table: {count, digest} per slot
   qvt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (SLOTS)
   ) u_slot_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign req_ch.ready = (state_ff == S_IDLE);
   assign csr_ch.ready = 1'b1;
   assign accept       = req_ch.valid && req_ch.ready;

   // front-end checks, in the order the vote is screened
   assign is_clear  = (req_ch.cmd >= CMD_CLEAR);
   assign who_idx   = ID_W'(req_ch.sender);
   assign len_bad   = (req_ch.msg_len == '0) || (req_ch.msg_len > max_len_ff);
   assign dup       = (int'(req_ch.sender) >= NODES) || mask_ff[who_idx];
   assign short_tag = (req_ch.msg_len < min_len_ff) || (req_ch.msg_tag != tag_ff);

   // walk: issue one read per cycle, evaluate the entry in the cycle after
   assign issue     = (state_ff == S_WALK) && (rd_ptr_ff < used_ff);
   assign ram_raddr = rd_ptr_ff[SLOT_W-1:0];
   assign rd_cnt    = ram_rdata[ENTRY_W-1 -: CNT_W];
   assign rd_dig    = ram_rdata[DIGEST_BITS-1:0];
   // a peer vote bumps only the first slot that holds its digest
   assign hit       = rvalid_ff && !own_ff && vote_ok_ff && !matched_ff && (rd_dig == dig_ff);
   assign new_cnt   = rd_cnt + CNT_W'(hit);
   assign last      = rvalid_ff && ((USED_W'(proc_idx_ff) + USED_W'(1)) == used_ff);

   assign rsp_free  = !rsp_valid_ff || rsp_ch.ready;
   assign store_new = !clear_ff && vote_ok_ff && !matched_ff && (used_ff < USED_W'(SLOTS));

   // RAM write: the matched entry during the walk, or the new slot at the end.
   // Each entry is read before it is written within one request, and the next
   // request cannot start its walk before the final write lands.
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = proc_idx_ff;
      ram_wdata = {new_cnt, rd_dig};
      if ((state_ff == S_WALK) && hit) begin
         ram_we = 1'b1;
      end else if ((state_ff == S_FINISH) && rsp_free && store_new) begin
         ram_we    = 1'b1;
         ram_waddr = used_ff[SLOT_W-1:0];
         ram_wdata = {CNT_W'(1), dig_ff};
      end
   end

   // configuration writes
   always_comb begin
      thr_in     = thr_ff;
      tag_in     = tag_ff;
      max_len_in = max_len_ff;
      min_len_in = min_len_ff;
      if (csr_ch.valid && csr_ch.ready) begin
         unique case (csr_idx_type'(csr_ch.index))
            CSR_THRESHOLD:    thr_in     = csr_ch.data[THR_W-1:0];
            CSR_EXPECTED_TAG: tag_in     = csr_ch.data[TAG_W-1:0];
            CSR_MAX_MSG_LEN:  max_len_in = csr_ch.data[LEN_W-1:0];
            CSR_MIN_MSG_LEN:  min_len_in = csr_ch.data[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in         = state_ff;
      mask_in          = mask_ff;
      used_in          = used_ff;
      own_valid_in     = own_valid_ff;
      own_slot_in      = own_slot_ff;
      clear_in         = clear_ff;
      own_in           = own_ff;
      vote_ok_in       = vote_ok_ff;
      status_in        = status_ff;
      dig_in           = dig_ff;
      who_in           = who_ff;
      rd_ptr_in        = rd_ptr_ff;
      rvalid_in        = 1'b0;
      proc_idx_in      = proc_idx_ff;
      matched_in       = matched_ff;
      done_in          = done_ff;
      cslot_in         = cslot_ff;
      cdig_in          = cdig_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in    = rsp_status_ff;
      rsp_done_in      = rsp_done_ff;
      rsp_cslot_in     = rsp_cslot_ff;
      rsp_cdig_in      = rsp_cdig_ff;
      rsp_own_valid_in = rsp_own_valid_ff;
      rsp_own_slot_in  = rsp_own_slot_ff;
      rsp_used_in      = rsp_used_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               // latch the request and its screening verdict
               clear_in   = is_clear;
               own_in     = (req_ch.cmd == CMD_OWN);
               dig_in     = req_ch.digest[DIGEST_BITS-1:0];
               who_in     = who_idx;
               vote_ok_in = 1'b0;
               if (is_clear) begin
                  status_in = ST_CLEARED;
               end else if (len_bad) begin
                  status_in = ST_BAD_LEN;
               end else if (dup) begin
                  status_in = ST_DUP_SENDER;
               end else if (short_tag) begin
                  status_in = ST_SHORT_TAG;
               end else begin
                  status_in  = ST_STORED;
                  vote_ok_in = 1'b1;
               end
               rd_ptr_in  = '0;
               matched_in = 1'b0;
               done_in    = 1'b0;
               cslot_in   = '0;
               cdig_in    = '0;
               // skip the walk when there is nothing to scan
               if (is_clear || (used_ff == '0)) begin
                  state_in = S_FINISH;
               end else begin
                  state_in = S_WALK;
               end
            end
         end

         S_WALK: begin
            rd_ptr_in   = rd_ptr_ff + USED_W'(issue);
            rvalid_in   = issue;
            proc_idx_in = rd_ptr_ff[SLOT_W-1:0];
            if (hit) begin
               matched_in = 1'b1;
            end
            // first slot at or above threshold, after this request's bump
            if (rvalid_ff && !done_ff && (new_cnt >= thr_ff)) begin
               done_in  = 1'b1;
               cslot_in = proc_idx_ff;
               cdig_in  = rd_dig;
            end
            if (last) begin
               state_in = S_FINISH;
            end
         end

         S_FINISH: begin
            // apply table updates and load the response in one step;
            // hold here while the previous response is still unread
            if (rsp_free) begin
               rsp_status_in = status_ff;
               rsp_done_in   = done_ff;
               rsp_cslot_in  = cslot_ff;
               rsp_cdig_in   = cdig_ff;
               if (clear_ff) begin
                  mask_in      = '0;
                  used_in      = '0;
                  own_valid_in = 1'b0;
                  own_slot_in  = '0;
                  rsp_done_in  = 1'b0;
                  rsp_cslot_in = '0;
                  rsp_cdig_in  = '0;
               end else if (vote_ok_ff) begin
                  if (matched_ff) begin
                     rsp_status_in   = ST_MATCHED;
                     mask_in[who_ff] = 1'b1;
                  end else if (store_new) begin
                     rsp_status_in   = ST_STORED;
                     mask_in[who_ff] = 1'b1;
                     used_in         = used_ff + USED_W'(1);
                     if (own_ff) begin
                        own_valid_in = 1'b1;
                        own_slot_in  = used_ff[SLOT_W-1:0];
                     end
                     // the fresh slot holds one vote
                     if (!done_ff && (THR_W'(1) >= thr_ff)) begin
                        rsp_done_in  = 1'b1;
                        rsp_cslot_in = used_ff[SLOT_W-1:0];
                        rsp_cdig_in  = dig_ff;
                     end
                  end else begin
                     rsp_status_in = ST_FULL;
                  end
               end
               rsp_own_valid_in = own_valid_in;
               rsp_own_slot_in  = own_valid_in ? own_slot_in : '0;
               rsp_used_in      = used_in;
               rsp_valid_in     = 1'b1;
               state_in         = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         thr_ff       <= THRESHOLD_RST;
         tag_ff       <= EXP_TAG_RST;
         max_len_ff   <= MAX_MSG_LEN_RST;
         min_len_ff   <= MIN_MSG_LEN_RST;
         mask_ff      <= '0;
         used_ff      <= '0;
         own_valid_ff <= 1'b0;
         own_slot_ff  <= '0;
         rvalid_ff    <= 1'b0;
         rd_ptr_ff    <= '0;
         matched_ff   <= 1'b0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         thr_ff       <= thr_in;
         tag_ff       <= tag_in;
         max_len_ff   <= max_len_in;
         min_len_ff   <= min_len_in;
         mask_ff      <= mask_in;
         used_ff      <= used_in;
         own_valid_ff <= own_valid_in;
         own_slot_ff  <= own_slot_in;
         rvalid_ff    <= rvalid_in;
         rd_ptr_ff    <= rd_ptr_in;
         matched_ff   <= matched_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      clear_ff         <= clear_in;
      own_ff           <= own_in;
      vote_ok_ff       <= vote_ok_in;
      status_ff        <= status_in;
      dig_ff           <= dig_in;
      who_ff           <= who_in;
      proc_idx_ff      <= proc_idx_in;
      cslot_ff         <= cslot_in;
      cdig_ff          <= cdig_in;
      rsp_status_ff    <= rsp_status_in;
      rsp_done_ff      <= rsp_done_in;
      rsp_cslot_ff     <= rsp_cslot_in;
      rsp_cdig_ff      <= rsp_cdig_in;
      rsp_own_valid_ff <= rsp_own_valid_in;
      rsp_own_slot_ff  <= rsp_own_slot_in;
      rsp_used_ff      <= rsp_used_in;
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.status          = rsp_status_ff;
   assign rsp_ch.complete        = rsp_done_ff;
   assign rsp_ch.complete_slot   = SLOT_OUT_W'(rsp_cslot_ff);
   assign rsp_ch.complete_digest = DIGEST_W'(rsp_cdig_ff);
   assign rsp_ch.own_valid       = rsp_own_valid_ff;
   assign rsp_ch.own_slot        = SLOT_OUT_W'(rsp_own_slot_ff);
   assign rsp_ch.used_slots      = USED_OUT_W'(rsp_used_ff);

endmodule
`default_nettype wire

### dv/testbench.sv
// Self-checking testbench for quorum_vote_tally_core: votes and clears are
// checked against an in-bench tally of the slot table. Depends on qvt_pkg,
// the qvt_req_if, qvt_rsp_if and qvt_csr_if channels and the core RTL.
`timescale 1ns / 1ps
module testbench;
   import qvt_pkg::*;

   localparam int CLK_PERIOD   = 12;
   localparam int TBL_SLOTS    = SLOTS_DEF;
   // the worst-case response time grows with the table size; leave a little margin
   localparam int DRAIN_CYCLES = TBL_SLOTS + 5;
   // cycles with no transaction on any channel before the run is declared hung
   localparam int STALL_LIMIT  = 3000;
   // the spare command code behaves as a clear
   localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

   typedef struct packed {
      logic [CMD_W-1:0]    cmd;
      logic [SENDER_W-1:0] sender;
      logic [LEN_W-1:0]    msg_len;
      logic [TAG_W-1:0]    msg_tag;
      logic [DIGEST_W-1:0] digest;
   } vote_type;

   typedef struct packed {
      status_type            status;
      logic                  complete;
      logic [SLOT_OUT_W-1:0] complete_slot;
      logic [DIGEST_W-1:0]   complete_digest;
      logic                  own_valid;
      logic [SLOT_OUT_W-1:0] own_slot;
      logic [USED_OUT_W-1:0] used_slots;
   } tally_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   qvt_req_if req_ch ();
   qvt_rsp_if rsp_ch ();
   qvt_csr_if csr_ch ();

   quorum_vote_tally_core uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // ---------------------------------------------------------------------
   // Tally predictor state: register copies plus the slot table as the
   // block should hold it after every accepted transaction.
   // ---------------------------------------------------------------------
   logic [THR_W-1:0]    thr_q    = THRESHOLD_RST;
   logic [TAG_W-1:0]    want_tag = EXP_TAG_RST;
   logic [LEN_W-1:0]    len_max  = MAX_MSG_LEN_RST;
   logic [LEN_W-1:0]    len_min  = MIN_MSG_LEN_RST;
   logic [DIGEST_W-1:0] tbl_digest [TBL_SLOTS] = '{default: '0};
   int                  tbl_votes  [TBL_SLOTS] = '{default: 0};
   logic [15:0]         voters   = '0;
   int                  tbl_used = 0;
   int                  own_idx  = 0;
   logic                own_held = 1'b0;

   // responses still owed by the block, oldest first
   tally_type tally_q[$];

   int faults         = 0;
   int votes_sent     = 0;
   int responses_seen = 0;
   int quorums_seen   = 0;
   int full_seen      = 0;
   int matches_seen   = 0;
   int settings_used  = 1;
   int quiet          = 0;
   bit idling         = 1'b1;

   logic [DIGEST_W-1:0] pool [6];
   int                  pool_n = 1;

   function automatic vote_type ballot(input logic [CMD_W-1:0] c,
                                       input logic [SENDER_W-1:0] s,
                                       input logic [LEN_W-1:0] l, input logic [TAG_W-1:0] t,
                                       input logic [DIGEST_W-1:0] d);
      vote_type v;
      v.cmd     = c;
      v.sender  = s;
      v.msg_len = l;
      v.msg_tag = t;
      v.digest  = d;
      return v;
   endfunction

   // Apply one transaction to the predicted table and return the response
   // that the block must produce for it.
   function automatic tally_type apply_vote(input vote_type v);
      tally_type  r;
      status_type st;
      bit         hit = 1'b0;
      if (v.cmd >= CMD_CLEAR) begin
         // clear empties the table, registers stay
         tbl_used = 0;
         voters   = '0;
         own_held = 1'b0;
         own_idx  = 0;
         foreach (tbl_votes[i]) tbl_votes[i] = 0;
         st = ST_CLEARED;
      end else if (v.msg_len == 0 || v.msg_len > len_max) begin
         st = ST_BAD_LEN;
      end else if (voters[v.sender]) begin
         st = ST_DUP_SENDER;
      end else if (v.msg_len < len_min || v.msg_tag != want_tag) begin
         st = ST_SHORT_TAG;
      end else begin
         // only peer votes merge into an existing slot
         if (v.cmd == CMD_PEER) begin
            for (int i = 0; i < tbl_used; i++) begin
               if (!hit && tbl_digest[i] == v.digest) begin
                  tbl_votes[i]++;
                  hit = 1'b1;
               end
            end
         end
         if (hit) begin
            voters[v.sender] = 1'b1;
            st = ST_MATCHED;
         end else if (tbl_used >= TBL_SLOTS) begin
            // a full table leaves the sender free to vote again
            st = ST_FULL;
         end else begin
            if (v.cmd == CMD_OWN) begin
               own_idx  = tbl_used;
               own_held = 1'b1;
            end
            tbl_digest[tbl_used] = v.digest;
            tbl_votes[tbl_used]  = 1;
            voters[v.sender]     = 1'b1;
            tbl_used++;
            st = ST_STORED;
         end
      end

      r        = '0;
      r.status = st;
      // walk down so the lowest qualifying slot wins
      for (int i = tbl_used - 1; i >= 0; i--) begin
         if (tbl_votes[i] >= thr_q) begin
            r.complete        = 1'b1;
            r.complete_slot   = SLOT_OUT_W'(i);
            r.complete_digest = tbl_digest[i];
         end
      end
      r.own_valid  = own_held;
      r.own_slot   = own_held ? SLOT_OUT_W'(own_idx) : '0;
      r.used_slots = USED_OUT_W'(tbl_used);
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Request side. Valid stays high from one transaction into the next when
   // no gap is drawn, so it is never dropped and raised in the same step.
   // ---------------------------------------------------------------------
   task automatic push_vote(input vote_type v);
      int gap;
      gap = idling ? $urandom_range(0, 15) : 0;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.cmd     <= v.cmd;
      req_ch.sender  <= v.sender;
      req_ch.msg_len <= v.msg_len;
      req_ch.msg_tag <= v.msg_tag;
      req_ch.digest  <= v.digest;
      do @(posedge clock); while (!req_ch.ready);
      tally_q.push_back(apply_vote(v));
      votes_sent++;
   endtask

   // Drop valid, hold until every owed response is back, then let the
   // block's own latency run out so it is fully idle.
   task automatic settle();
      req_ch.valid <= 1'b0;
      while (tally_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // One register write transaction; the caller drops csr valid.
   task automatic write_reg(input csr_idx_type idx, input logic [CSR_DATA_W-1:0] wdata);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= wdata;
      do @(posedge clock); while (!csr_ch.ready);
      case (idx)
         CSR_THRESHOLD:    thr_q    = wdata[THR_W-1:0];
         CSR_EXPECTED_TAG: want_tag = wdata[TAG_W-1:0];
         CSR_MAX_MSG_LEN:  len_max  = wdata[LEN_W-1:0];
         CSR_MIN_MSG_LEN:  len_min  = wdata[LEN_W-1:0];
         default: ;
      endcase
   endtask

   // Write all four registers while idle; upper data bits carry junk that
   // the block must drop.
   task automatic program_regs(input logic [THR_W-1:0] thr, input logic [TAG_W-1:0] tag,
                               input logic [LEN_W-1:0] lmax, input logic [LEN_W-1:0] lmin);
      logic [CSR_DATA_W-1:0] junk;
      settle();
      junk = CSR_DATA_W'($urandom);
      write_reg(CSR_THRESHOLD, {junk[CSR_DATA_W-1:THR_W], thr});
      junk = CSR_DATA_W'($urandom);
      write_reg(CSR_EXPECTED_TAG, {junk[CSR_DATA_W-1:TAG_W], tag});
      junk = CSR_DATA_W'($urandom);
      write_reg(CSR_MAX_MSG_LEN, {junk[CSR_DATA_W-1:LEN_W], lmax});
      junk = CSR_DATA_W'($urandom);
      write_reg(CSR_MIN_MSG_LEN, {junk[CSR_DATA_W-1:LEN_W], lmin});
      csr_ch.valid <= 1'b0;
      settings_used++;
   endtask

   // ---------------------------------------------------------------------
   // Response side: random stalls per transaction, same pattern as above.
   // ---------------------------------------------------------------------
   initial begin
      int stall;
      rsp_ch.ready = 1'b0;
      forever begin
         stall = idling ? $urandom_range(0, 15) : 0;
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
      end
   end

   // Compare every response transaction with the oldest prediction.
   always @(posedge clock) begin
      tally_type seen;
      tally_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         seen.status          = status_type'(rsp_ch.status);
         seen.complete        = rsp_ch.complete;
         seen.complete_slot   = rsp_ch.complete_slot;
         seen.complete_digest = rsp_ch.complete_digest;
         seen.own_valid       = rsp_ch.own_valid;
         seen.own_slot        = rsp_ch.own_slot;
         seen.used_slots      = rsp_ch.used_slots;
         responses_seen++;
         if (tally_q.size() == 0) begin
            faults++;
            if (faults <= 10)
               $display("%0t: response with none outstanding, status %0d", $time, seen.status);
         end else begin
            want = tally_q.pop_front();
            if (want.complete) quorums_seen++;
            if (want.status == ST_FULL) full_seen++;
            if (want.status == ST_MATCHED) matches_seen++;
            if (seen !== want) begin
               faults++;
               if (faults <= 10) begin
                  $display("%0t: mismatch (expected/actual) status %0d/%0d",
                           $time, want.status, seen.status);
                  $display("   complete %0b/%0b slot %0d/%0d",
                           want.complete, seen.complete,
                           want.complete_slot, seen.complete_slot);
                  $display("   digest %h/%h own %0b:%0d/%0b:%0d used %0d/%0d",
                           want.complete_digest, seen.complete_digest, want.own_valid,
                           want.own_slot, seen.own_valid, seen.own_slot, want.used_slots,
                           seen.used_slots);
               end
            end
         end
      end
   end

   // Watchdog: advance on any transaction, give up after a long silence.
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         quiet <= 0;
      end else if (quiet >= STALL_LIMIT) begin
         $display("Watchdog: no transaction for %0d cycles", STALL_LIMIT);
         $display("TB_ERROR");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Reset register values: length and tag checks, duplicate sender, merge,
   // own vote, table full and both clear codes.
   task automatic test_reset_defaults();
      push_vote(ballot(CMD_CLEAR, 0, 0, 0, '0));
      push_vote(ballot(CMD_PEER, 0, 0, 0, 64'd1));               // zero length
      push_vote(ballot(CMD_PEER, 0, 47, 0, 64'd1));              // one byte short
      push_vote(ballot(CMD_PEER, 0, 48, 8'h01, 64'd1));          // wrong tag
      push_vote(ballot(CMD_PEER, 0, 4095, 0, '0));               // stored, quorum of one
      push_vote(ballot(CMD_PEER, 0, 100, 0, '0));                // same sender again
      push_vote(ballot(CMD_PEER, 15, 48, 0, '1));                // second slot
      push_vote(ballot(CMD_PEER, 3, 48, 0, '0));                 // merges into slot 0
      push_vote(ballot(CMD_OWN, 4, 60, 0, '0));                  // own vote never merges
      push_vote(ballot(CMD_PEER, 5, 200, 0, 64'h5555_5555_5555_5555));
      push_vote(ballot(CMD_PEER, 6, 200, 0, 64'hAAAA_AAAA_AAAA_AAAA)); // table full
      push_vote(ballot(CMD_PEER, 6, 200, 0, '1));                // full did not mark sender
      push_vote(ballot(CMD_OWN, 7, 48, 0, '1));                  // own needs a slot: full
      push_vote(ballot(CMD_SPARE, 9, 300, 8'h33, 64'd7));        // spare code clears
   endtask

   // Register extremes: zero and out-of-range thresholds, tightest length
   // window, widest tag, repeated own vote.
   task automatic test_register_extremes();
      logic [DIGEST_W-1:0] d;
      d = {$urandom, $urandom};
      program_regs(5'd0, 8'hFF, 12'd1, 12'd1);
      push_vote(ballot(CMD_PEER, 9, 1, 8'hFF, 64'h8000_0000_0000_0001)); // zero threshold
      push_vote(ballot(CMD_PEER, 10, 2, 8'hFF, d));               // above max length
      push_vote(ballot(CMD_CLEAR, 0, 0, 0, '0));                  // empty table never complete
      program_regs(5'd2, 8'h5A, 12'd4095, 12'd4095);
      push_vote(ballot(CMD_OWN, 1, 4094, 8'h5A, d));              // short
      push_vote(ballot(CMD_OWN, 1, 4095, 8'h5A, d));              // own in slot 0
      push_vote(ballot(CMD_OWN, 2, 4095, 8'h5A, d));              // own moves to slot 1
      push_vote(ballot(CMD_PEER, 3, 4095, 8'h5A, d));             // slot 0 reaches two
      program_regs(5'd31, 8'h00, 12'd4095, 12'd48);               // table survives writes
      push_vote(ballot(CMD_PEER, 4, 4095, 8'h00, d));             // unreachable threshold
   endtask

   // Random phases: mostly well-formed votes over a small digest pool, with
   // clears and random noise mixed in. Phase 3 collects a full 16-node quorum;
   // every third phase runs without idling on either side.
   task automatic test_random_traffic();
      vote_type v;
      int       thr;
      int       lmin;
      int       lmax;
      int       roll;
      int       clear_pct;
      for (int phase = 0; phase < 8; phase++) begin
         thr  = (phase == 3) ? 16 : $urandom_range(0, 6);
         lmin = (phase == 5) ? 1 : $urandom_range(1, 300);
         lmax = (phase == 5) ? 4095 : $urandom_range(lmin, 4095);
         program_regs(THR_W'(thr), TAG_W'($urandom_range(0, 255)), LEN_W'(lmax), LEN_W'(lmin));
         pool_n = (phase == 3) ? 1 : $urandom_range(1, 6);
         foreach (pool[i]) pool[i] = {$urandom, $urandom};
         clear_pct = (phase == 3) ? 2 : 8;
         idling = (phase % 3) != 2;
         push_vote(ballot(CMD_CLEAR, 0, 0, 0, '0));
         for (int n = 0; n < 48; n++) begin
            // hold the sender once per phase until everything is back
            if (n == 24) settle();
            roll = $urandom_range(0, 99);
            if (roll < clear_pct) begin
               v = ballot(CMD_CLEAR, SENDER_W'($urandom_range(0, 15)),
                          LEN_W'($urandom_range(0, 4095)), TAG_W'($urandom_range(0, 255)),
                          {$urandom, $urandom});
            end else if (roll < clear_pct + 12) begin
               v = ballot(CMD_W'($urandom_range(0, 3)), SENDER_W'($urandom_range(0, 15)),
                          LEN_W'($urandom_range(0, 4095)), TAG_W'($urandom_range(0, 255)),
                          {$urandom, $urandom});
            end else begin
               v = ballot(($urandom_range(0, 7) == 0) ? CMD_OWN : CMD_PEER,
                          (phase == 3) ? SENDER_W'(n) : SENDER_W'($urandom_range(0, 15)),
                          LEN_W'($urandom_range(len_min, len_max)), want_tag,
                          pool[$urandom_range(0, pool_n - 1)]);
            end
            push_vote(v);
         end
      end
      idling = 1'b1;
   endtask

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      req_ch.valid   = 1'b0;
      req_ch.cmd     = CMD_PEER;
      req_ch.sender  = '0;
      req_ch.msg_len = '0;
      req_ch.msg_tag = '0;
      req_ch.digest  = '0;
      csr_ch.valid   = 1'b0;
      csr_ch.index   = CSR_THRESHOLD;
      csr_ch.data    = '0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_register_extremes();
      test_random_traffic();
      settle();

      $display("Ran %0d vote/clear transactions across %0d register settings, %0d responses.",
               votes_sent, settings_used, responses_seen);
      $display("Saw %0d complete certificates, %0d merges and %0d full-table rejects.",
               quorums_seen, matches_seen, full_seen);
      if (faults == 0 && tally_q.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("%0d failures, %0d responses missing", faults, tally_q.size());
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/qvt_pkg.sv
rtl/qvt_req_if.sv
rtl/qvt_rsp_if.sv
rtl/qvt_csr_if.sv
rtl/qvt_ram.sv
rtl/quorum_vote_tally_core.sv
dv/testbench.sv
